[design/chroma_420_subsampler_unit_macros.svh]
// Assertion macros shared by the chroma subsampler RTL.
// Uses the clk_i and rst_ni names of the module that includes it.
`ifndef CHROMA_420_SUBSAMPLER_UNIT_MACROS_SVH
`define CHROMA_420_SUBSAMPLER_UNIT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define C420_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define C420_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/c420_pkg.sv]
// Package of the 4:2:0 chroma subsampler: sizes, register indexes,
// the command that passes from front to back, and the frame size clamp.
`default_nettype none

package c420_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int STORE_DEPTH  = MAX_WIDTH / 2;

  localparam int CFG_W   = 12;
  localparam int IDX_W   = 2;
  localparam int SIZE_W  = $clog2((MAX_WIDTH > HEIGHT_LIMIT ? MAX_WIDTH : HEIGHT_LIMIT) + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
  localparam int SLOT_W  = $clog2(STORE_DEPTH);
  localparam int PIX_W   = 8;
  localparam int PART_W  = PIX_W + 1;
  localparam int ENTRY_W = 2 * PART_W;
  localparam int SUM_W   = PIX_W + 3;
  localparam int AVG_W   = 10;
  localparam int POS_W   = 10;

  localparam logic [AVG_W-1:0] AVG_MAX = AVG_W'(1020);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic             MODE_RESET   = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);

  localparam logic [SIZE_W-1:0] WIDTH_LIMIT  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_LIM_S = SIZE_W'(HEIGHT_LIMIT);

  typedef enum logic [IDX_W-1:0] {
    CFG_CHROMA_MODE  = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic               mode;
    logic [PIX_W-1:0]   u;
    logic [PIX_W-1:0]   v;
    logic [PIX_W-1:0]   pend_u;
    logic [PIX_W-1:0]   pend_v;
    logic [ENTRY_W-1:0] stored;
    logic [POS_W-1:0]   crow;
    logic [POS_W-1:0]   ccol;
    logic               last;
  } cmd_t;

  function automatic logic [SIZE_W-1:0] used_size(input logic [CFG_W-1:0]  val,
                                                  input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] s;
    s = (SIZE_W'(val) > limit) ? limit : SIZE_W'(val);
    s[0] = 1'b0;
    if (s < SIZE_W'(2)) s = SIZE_W'(2);
    return s;
  endfunction

endpackage

`default_nettype wire

[design/chroma_420_subsampler_unit.sv]
// Top level of the 4:2:0 chroma subsampler: front, command queue and back.
// Depends on c420_pkg, c420_front, c420_fifo and c420_back.
`default_nettype none

// Takes one U/V pixel per clock in raster order and returns one 4:2:0 sample
// per 2x2 block: in vertical mode twice the sum of the even-column pair of
// the two rows, in box mode the sum of all four pixels, both as unsigned
// values with two fraction bits, clamped to 1020. A pixel is taken every
// cycle while the output side drains; the result of the pixel that completes
// its block passes through the registered line store read, the command queue
// and the output register before it leaves the block.
// The rate is set by the single-port line store, which serves one write or
// one read per pixel. The line store holds 1024 entries of 18 bits and is not
// cleared after reset; a whole even row must be fed before its odd row.
// The user must write frame size and mode only while the block is idle; the block does not enforce this.
module chroma_420_subsampler_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [c420_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [c420_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [c420_pkg::PIX_W-1:0]   u_sample_i,
  input  wire logic [c420_pkg::PIX_W-1:0]   v_sample_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [c420_pkg::AVG_W-1:0]        u_average_o,
  output logic [c420_pkg::AVG_W-1:0]        v_average_o,
  output logic [c420_pkg::POS_W-1:0]        chroma_row_o,
  output logic [c420_pkg::POS_W-1:0]        chroma_col_o,
  output logic                              frame_end_o
);
  import c420_pkg::*;

  cfg_wr_t               cfg;
  cmd_t                  front_cmd, queue_cmd;
  logic                  front_valid;
  logic                  queue_empty, queue_pop;
  logic [FIFO_CNT_W-1:0] queue_cnt;

  always_comb begin
    cfg.we    = cfg_we_i;
    cfg.index = cfg_index_i;
    cfg.data  = cfg_wdata_i;
  end

  c420_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push),
    .u_i         (u_sample_i),
    .v_i         (v_sample_i),
    .full_o      (full),
    .fifo_cnt_i  (queue_cnt),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  c420_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .pop_i   (queue_pop),
    .data_o  (queue_cmd),
    .empty_o (queue_empty),
    .count_o (queue_cnt)
  );

  c420_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (queue_cmd),
    .cmd_empty_i  (queue_empty),
    .cmd_pop_o    (queue_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .u_average_o  (u_average_o),
    .v_average_o  (v_average_o),
    .chroma_row_o (chroma_row_o),
    .chroma_col_o (chroma_col_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire

[design/c420_ram.sv]
// Generic single-port RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module c420_ram #(
  parameter int WIDTH  = 18,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/c420_fifo.sv]
// Short command queue between the front and the back of the subsampler.
// Depends on c420_pkg for the command type and the depth.
`default_nettype none
`include "chroma_420_subsampler_unit_macros.svh"

module c420_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire c420_pkg::cmd_t                data_i,
  input  wire logic                          pop_i,
  output c420_pkg::cmd_t                     data_o,
  output logic                               empty_o,
  output logic [c420_pkg::FIFO_CNT_W-1:0]    count_o
);
  import c420_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `C420_ASSERT(a_fifo_no_overflow, push_i |-> (cnt_q < FIFO_CNT_W'(FIFO_DEPTH)), "queue overflow")
  `C420_ASSERT(a_fifo_cnt_range, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

[design/c420_front.sv]
// Front of the subsampler: configuration registers, raster position, line store
// access and classification of each pixel. Depends on c420_pkg and c420_ram.
`default_nettype none
`include "chroma_420_subsampler_unit_macros.svh"

module c420_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire c420_pkg::cfg_wr_t             cfg_i,
  input  wire logic                          push_i,
  input  wire logic [c420_pkg::PIX_W-1:0]    u_i,
  input  wire logic [c420_pkg::PIX_W-1:0]    v_i,
  output logic                               full_o,
  input  wire logic [c420_pkg::FIFO_CNT_W-1:0] fifo_cnt_i,
  output logic                               cmd_valid_o,
  output c420_pkg::cmd_t                     cmd_o
);
  import c420_pkg::*;

  logic             mode_q;
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic [PIX_W-1:0] pend_u_q, pend_v_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             stg_valid_q;
  cmd_t             stg_q, stg_d;

  logic [SIZE_W-1:0]  width_used, height_used;
  logic [SIZE_W-1:0]  col_c, row_t, row_c, col_n, row_n;
  logic               col_wrap, odd_col, odd_row, hit, emit, accept;
  logic [SLOT_W-1:0]  slot;
  logic               ram_we, ram_re, pend_we;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    width_used  = used_size(width_q, WIDTH_LIMIT);
    height_used = used_size(height_q, HEIGHT_LIM_S);
    col_wrap    = SIZE_W'(col_q) >= width_used;
    col_c       = col_wrap ? '0 : SIZE_W'(col_q);
    row_t       = SIZE_W'(row_q) + SIZE_W'(col_wrap);
    row_c       = (row_t >= height_used) ? '0 : row_t;
    col_n       = col_c + SIZE_W'(1);
    row_n       = row_c + SIZE_W'(1);
    if (col_n >= width_used) begin
      col_d = '0;
      row_d = (row_n >= height_used) ? '0 : row_n[ROW_W-1:0];
    end else begin
      col_d = col_n[COL_W-1:0];
      row_d = row_c[ROW_W-1:0];
    end

    odd_col = col_c[0];
    odd_row = row_c[0];
    slot    = col_c[COL_W-1:1];
    hit     = mode_q ? odd_col : !odd_col;
    emit    = odd_row && hit;

    full_o = (FIFO_CNT_W'(fifo_cnt_i) + FIFO_CNT_W'(stg_valid_q)) >= FIFO_CNT_W'(FIFO_DEPTH);
    accept = push_i && !full_o;

    ram_we  = accept && !odd_row && hit;
    ram_re  = accept && odd_row;
    pend_we = accept && mode_q && !odd_col;
    if (mode_q) begin
      ram_wdata = {PART_W'(pend_v_q) + PART_W'(v_i), PART_W'(pend_u_q) + PART_W'(u_i)};
    end else begin
      ram_wdata = {PART_W'(v_i), PART_W'(u_i)};
    end

    stg_d        = stg_q;
    stg_d.mode   = mode_q;
    stg_d.u      = u_i;
    stg_d.v      = v_i;
    stg_d.pend_u = pend_u_q;
    stg_d.pend_v = pend_v_q;
    stg_d.crow   = POS_W'(row_c >> 1);
    stg_d.ccol   = POS_W'(col_c >> 1);
    stg_d.last   = ((row_c >> 1) == ((height_used >> 1) - SIZE_W'(1))) &&
                   ((col_c >> 1) == ((width_used >> 1) - SIZE_W'(1)));

    cmd_o        = stg_q;
    cmd_o.stored = ram_rdata;
  end

  assign cmd_valid_o = stg_valid_q;

  c420_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .addr_i  (slot),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RESET;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      pend_u_q    <= '0;
      pend_v_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        unique case (cfg_index_e'(cfg_i.index))
          CFG_CHROMA_MODE:  mode_q   <= cfg_i.data[0];
          CFG_FRAME_WIDTH:  width_q  <= cfg_i.data;
          CFG_FRAME_HEIGHT: height_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (pend_we) begin
        pend_u_q <= u_i;
        pend_v_q <= v_i;
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      stg_valid_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      stg_q <= stg_d;
    end
  end

  `C420_ASSERT(a_stage_from_request, stg_valid_q |-> $past(accept), "stage loaded without request")
  `C420_ASSERT(a_queue_room, (FIFO_CNT_W'(fifo_cnt_i) + FIFO_CNT_W'(stg_valid_q)) <= FIFO_CNT_W'(FIFO_DEPTH), "queue room lost")

endmodule

`default_nettype wire

[design/c420_back.sv]
// Back of the subsampler: forms the averaged chroma sample from a queued
// command and holds it in the output register. Depends on c420_pkg.
`default_nettype none
`include "chroma_420_subsampler_unit_macros.svh"

module c420_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire c420_pkg::cmd_t              cmd_i,
  input  wire logic                        cmd_empty_i,
  output logic                             cmd_pop_o,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output logic [c420_pkg::AVG_W-1:0]       u_average_o,
  output logic [c420_pkg::AVG_W-1:0]       v_average_o,
  output logic [c420_pkg::POS_W-1:0]       chroma_row_o,
  output logic [c420_pkg::POS_W-1:0]       chroma_col_o,
  output logic                             frame_end_o
);
  import c420_pkg::*;

  logic             out_valid_q;
  logic [AVG_W-1:0] u_avg_q, v_avg_q, u_avg_d, v_avg_d;
  logic [POS_W-1:0] crow_q, ccol_q;
  logic             last_q;
  logic [SUM_W-1:0] sum_u, sum_v;
  logic [PART_W-1:0] st_u, st_v;
  logic             take;

  always_comb begin
    st_u = cmd_i.stored[PART_W-1:0];
    st_v = cmd_i.stored[ENTRY_W-1:PART_W];
    if (cmd_i.mode) begin
      sum_u = SUM_W'(st_u) + SUM_W'(cmd_i.pend_u) + SUM_W'(cmd_i.u);
      sum_v = SUM_W'(st_v) + SUM_W'(cmd_i.pend_v) + SUM_W'(cmd_i.v);
    end else begin
      sum_u = (SUM_W'(st_u) + SUM_W'(cmd_i.u)) << 1;
      sum_v = (SUM_W'(st_v) + SUM_W'(cmd_i.v)) << 1;
    end
    u_avg_d = (sum_u > SUM_W'(AVG_MAX)) ? AVG_MAX : AVG_W'(sum_u);
    v_avg_d = (sum_v > SUM_W'(AVG_MAX)) ? AVG_MAX : AVG_W'(sum_v);
  end

  assign take      = !cmd_empty_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = take;
  assign empty_o   = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      u_avg_q <= u_avg_d;
      v_avg_q <= v_avg_d;
      crow_q  <= cmd_i.crow;
      ccol_q  <= cmd_i.ccol;
      last_q  <= cmd_i.last;
    end
  end

  assign u_average_o  = u_avg_q;
  assign v_average_o  = v_avg_q;
  assign chroma_row_o = crow_q;
  assign chroma_col_o = ccol_q;
  assign frame_end_o  = last_q;

  `C420_ASSERT(a_take_fills_output, take |=> out_valid_q, "taken command not presented")

endmodule

`default_nettype wire
